[hw/rtl/gprfc_pkg.sv]
// Shared control types for the gamepad report frame combiner.
package gprfc_pkg;

    // Per-cycle commands from the sequencer to every averaging lane.
    typedef struct packed {
        logic copy;      // first report of a frame: take the sample as the mean
        logic load;      // later report: latch sample and kept mean, clear accumulator
        logic mul;       // one shift-add step of mean * count
        logic mul_bit;   // current count bit, least significant first
        logic add_v;     // add the new sample to the product
        logic absval;    // split the numerator into sign and magnitude
        logic div;       // one restoring division step
        logic fix;       // restore the sign of the quotient and keep it
        logic out_load;  // capture the merged values into the output register
    } lane_ctl_t;

endpackage

[hw/rtl/gprfc_lane.sv]
// One averaging lane: bit-serial multiply by the count, add, then bit-serial divide.
module gprfc_lane
    import gprfc_pkg::*;
#(
    parameter int AW = 17,
    parameter int CW = 8
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  lane_ctl_t       ctl,
    input  logic [CW:0]     divisor,
    input  logic [AW-1:0]   sample,
    output logic [AW-1:0]   mean
);

    localparam int M = AW + CW;

    logic [AW-1:0] kept_reg;
    logic [AW-1:0] v_reg;
    logic [M-1:0]  mcand_reg;
    logic [M-1:0]  acc_reg;
    logic [M-1:0]  quo_reg;
    logic [CW-1:0] rem_reg;
    logic          neg_reg;

    logic [CW:0]   trial;
    logic [CW:0]   diff;
    logic          fits;
    logic [AW-1:0] quo_low;

    assign trial   = {rem_reg, quo_reg[M-1]};
    assign diff    = trial - divisor;
    assign fits    = trial >= divisor;
    assign quo_low = quo_reg[AW-1:0];
    assign mean    = kept_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_reg <= '0;
        end
        else if (ctl.copy)
        begin
            kept_reg <= sample;
        end
        else if (ctl.fix)
        begin
            kept_reg <= neg_reg ? (AW'(0) - quo_low) : quo_low;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            v_reg     <= sample;
            mcand_reg <= {{(M-AW){kept_reg[AW-1]}}, kept_reg};
            acc_reg   <= '0;
        end
        else if (ctl.mul)
        begin
            if (ctl.mul_bit)
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg <= {mcand_reg[M-2:0], 1'b0};
        end
        else if (ctl.add_v)
        begin
            acc_reg <= acc_reg + {{(M-AW){v_reg[AW-1]}}, v_reg};
        end
        else if (ctl.absval)
        begin
            neg_reg <= acc_reg[M-1];
            quo_reg <= acc_reg[M-1] ? (M'(0) - acc_reg) : acc_reg;
            rem_reg <= '0;
        end
        else if (ctl.div)
        begin
            if (fits)
            begin
                rem_reg <= diff[CW-1:0];
            end
            else
            begin
                rem_reg <= trial[CW-1:0];
            end
            quo_reg <= {quo_reg[M-2:0], fits};
        end
    end

endmodule

[hw/rtl/gprfc_ctrl.sv]
// Sequencer for the combiner: handshakes, report count and lane step commands.
module gprfc_ctrl
    import gprfc_pkg::*;
#(
    parameter int AW        = 17,
    parameter int CW        = 8,
    parameter int COUNT_MAX = 255
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          frame_start,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    output lane_ctl_t     ctl,
    output logic [CW:0]   divisor,
    output logic [CW-1:0] count
);

    localparam int M  = AW + CW;
    localparam int PW = $clog2(M);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_ABS,
        ST_DIV,
        ST_FIX,
        ST_DONE
    } state_t;

    state_t        state_reg;
    logic [PW-1:0] step_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] nbits_reg;
    logic [CW:0]   divisor_reg;
    logic          out_valid_reg;

    logic accept;
    logic out_free;
    logic restart;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign restart  = frame_start || (count_reg == '0);

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign divisor   = divisor_reg;
    assign count     = count_reg;

    always_comb
    begin
        ctl          = '0;
        ctl.copy     = accept && restart;
        ctl.load     = accept && !restart;
        ctl.mul      = (state_reg == ST_MUL);
        ctl.mul_bit  = nbits_reg[0];
        ctl.add_v    = (state_reg == ST_ADD);
        ctl.absval   = (state_reg == ST_ABS);
        ctl.div      = (state_reg == ST_DIV);
        ctl.fix      = (state_reg == ST_FIX);
        ctl.out_load = (state_reg == ST_DONE) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            nbits_reg     <= '0;
            divisor_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (restart)
                        begin
                            count_reg <= CW'(1);
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            nbits_reg   <= count_reg;
                            divisor_reg <= {1'b0, count_reg} + 1'b1;
                            step_reg    <= PW'(CW - 1);
                            state_reg   <= ST_MUL;
                        end
                    end
                end
                ST_MUL:
                begin
                    nbits_reg <= nbits_reg >> 1;
                    if (step_reg == '0)
                    begin
                        state_reg <= ST_ADD;
                    end
                    else
                    begin
                        step_reg <= step_reg - 1'b1;
                    end
                end
                ST_ADD:
                begin
                    state_reg <= ST_ABS;
                end
                ST_ABS:
                begin
                    step_reg  <= PW'(M - 1);
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (step_reg == '0)
                    begin
                        state_reg <= ST_FIX;
                    end
                    else
                    begin
                        step_reg <= step_reg - 1'b1;
                    end
                end
                ST_FIX:
                begin
                    if (count_reg < CW'(COUNT_MAX))
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (ctl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

[hw/rtl/gamepad_report_frame_combiner.sv]
// Top level of the gamepad report frame combiner: lanes, button merge and output register.
//
// Usage: controller reports enter on the input channel (in_valid / in_stall); each
// accepted transaction yields exactly one merged transaction on the output channel
// (out_valid / out_stall). A report flagged frame_start, or the first report after
// reset, is copied as the new frame state. Every later report ANDs its buttons into
// the kept flags and updates the four stick and two trigger means with
// (mean * n + sample) / (n + 1), truncating toward zero; n then rises, saturating at
// COUNT_MAX. Six lanes work in parallel; each runs a shift-add multiply by n, one bit
// of n per cycle, then a restoring divide, one quotient bit per cycle.
// Sequence: a copied report goes straight to the done state, where the result waits
// to be captured into the output register; the next report is taken once the sequencer
// is back in idle. An averaged report runs the multiply, add, sign split, divide, fix
// and done states before the next report is taken. One report is in work at a time.
// The result sits in an output register, so a new report is taken while the previous
// result is still stalled; a finished result waits in the sequencer until the output
// register is free. Reset clears the count, the kept means and the output valid.
module gamepad_report_frame_combiner
    import gprfc_pkg::*;
#(
    parameter int BUTTON_BITS = 16,
    parameter int AXIS_BITS   = 16,
    parameter int COUNT_MAX   = 255
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        frame_start,
    input  logic [BUTTON_BITS-1:0]      buttons,
    input  logic signed [AXIS_BITS-1:0] left_x,
    input  logic signed [AXIS_BITS-1:0] left_y,
    input  logic signed [AXIS_BITS-1:0] right_x,
    input  logic signed [AXIS_BITS-1:0] right_y,
    input  logic [AXIS_BITS-1:0]        left_trigger,
    input  logic [AXIS_BITS-1:0]        right_trigger,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [BUTTON_BITS-1:0]      merged_buttons,
    output logic signed [AXIS_BITS-1:0] mean_left_x,
    output logic signed [AXIS_BITS-1:0] mean_left_y,
    output logic signed [AXIS_BITS-1:0] mean_right_x,
    output logic signed [AXIS_BITS-1:0] mean_right_y,
    output logic [AXIS_BITS-1:0]        mean_left_trigger,
    output logic [AXIS_BITS-1:0]        mean_right_trigger,
    output logic [7:0]                  reports_seen
);

    // Lanes carry one extra bit so that sticks and triggers share one signed datapath.
    localparam int AW    = AXIS_BITS + 1;
    localparam int CW    = $clog2(COUNT_MAX + 1);
    localparam int LANES = 6;

    lane_ctl_t     ctl;
    logic [CW:0]   divisor;
    logic [CW-1:0] count;
    logic [CW+7:0] count_ext;

    logic [AW-1:0] lane_in   [LANES];
    logic [AW-1:0] lane_mean [LANES];

    logic [BUTTON_BITS-1:0] kept_buttons_reg;
    logic [BUTTON_BITS-1:0] out_buttons_reg;
    logic [AXIS_BITS-1:0]   out_mean_reg [LANES];
    logic [7:0]             out_count_reg;

    // Sticks are sign extended, triggers zero extended.
    assign lane_in[0] = {left_x[AXIS_BITS-1], left_x};
    assign lane_in[1] = {left_y[AXIS_BITS-1], left_y};
    assign lane_in[2] = {right_x[AXIS_BITS-1], right_x};
    assign lane_in[3] = {right_y[AXIS_BITS-1], right_y};
    assign lane_in[4] = {1'b0, left_trigger};
    assign lane_in[5] = {1'b0, right_trigger};

    gprfc_ctrl #(
        .AW        (AW),
        .CW        (CW),
        .COUNT_MAX (COUNT_MAX)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .frame_start (frame_start),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .ctl         (ctl),
        .divisor     (divisor),
        .count       (count)
    );

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        gprfc_lane #(
            .AW (AW),
            .CW (CW)
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .divisor (divisor),
            .sample  (lane_in[g]),
            .mean    (lane_mean[g])
        );
    end

    // The button merge is a single AND, done at acceptance.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_buttons_reg <= '0;
        end
        else if (ctl.copy)
        begin
            kept_buttons_reg <= buttons;
        end
        else if (ctl.load)
        begin
            kept_buttons_reg <= kept_buttons_reg & buttons;
        end
    end

    // The count is reported modulo 256 when it is wider than the port.
    assign count_ext = {8'b0, count};

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            out_buttons_reg <= kept_buttons_reg;
            for (int i = 0; i < LANES; i++)
            begin
                out_mean_reg[i] <= lane_mean[i][AXIS_BITS-1:0];
            end
            out_count_reg <= count_ext[7:0];
        end
    end

    assign merged_buttons     = out_buttons_reg;
    assign mean_left_x        = out_mean_reg[0];
    assign mean_left_y        = out_mean_reg[1];
    assign mean_right_x       = out_mean_reg[2];
    assign mean_right_y       = out_mean_reg[3];
    assign mean_left_trigger  = out_mean_reg[4];
    assign mean_right_trigger = out_mean_reg[5];
    assign reports_seen       = out_count_reg;

    // An accepted report always keeps the block busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after an accepted report");

    // At most one lane command is active in any cycle.
    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.copy, ctl.load, ctl.mul, ctl.add_v, ctl.absval, ctl.div, ctl.fix}))
        else $error("lane commands overlap");

    // Every result carries a non-zero report count.
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> (count != '0))
        else $error("result issued with a zero report count");

    // A result is captured only when the output register is free.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !ctl.out_load)
        else $error("output register overwritten while stalled");

endmodule

[dv/tb.sv]
// Self-checking testbench for the gamepad report frame combiner.
`timescale 1ns / 100ps

module tb;

    localparam int BTN_W        = 16;
    localparam int AXIS_W       = 16;
    localparam int COUNT_LIMIT  = 255;
    // Generous ceiling: roughly ten times the slowest legal run of about 600 reports.
    localparam int CYCLE_LIMIT  = 600000;
    // Time to watch after the last result, to cover any straggler at the end.
    localparam int SETTLE_CYCLES = 120;
    localparam int MAX_REPORTED = 10;

    // One controller report as it is presented on the input channel.
    typedef struct packed {
        logic                   frame_start;
        logic [BTN_W-1:0]       buttons;
        logic [3:0][AXIS_W-1:0] sticks;     // left_x, left_y, right_x, right_y
        logic [1:0][AXIS_W-1:0] triggers;   // left, right
    } pad_report_t;

    // One merged transaction as it leaves the output channel.
    typedef struct packed {
        logic [BTN_W-1:0]       buttons;
        logic [3:0][AXIS_W-1:0] sticks;
        logic [1:0][AXIS_W-1:0] triggers;
        logic [7:0]             seen;
    } frame_merge_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     frame_start = 1'b0;
    logic [BTN_W-1:0]         buttons = '0;
    logic signed [AXIS_W-1:0] left_x = '0;
    logic signed [AXIS_W-1:0] left_y = '0;
    logic signed [AXIS_W-1:0] right_x = '0;
    logic signed [AXIS_W-1:0] right_y = '0;
    logic [AXIS_W-1:0]        left_trigger = '0;
    logic [AXIS_W-1:0]        right_trigger = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [BTN_W-1:0]         merged_buttons;
    logic signed [AXIS_W-1:0] mean_left_x;
    logic signed [AXIS_W-1:0] mean_left_y;
    logic signed [AXIS_W-1:0] mean_right_x;
    logic signed [AXIS_W-1:0] mean_right_y;
    logic [AXIS_W-1:0]        mean_left_trigger;
    logic [AXIS_W-1:0]        mean_right_trigger;
    logic [7:0]               reports_seen;

    // Merged results still owed by the block, oldest first.
    frame_merge_t expected_merges[$];

    // Our own copy of the frame state, kept in wide signed integers so that the
    // product of mean and count never loses bits before the divide.
    int           frame_reports = 0;
    logic [BTN_W-1:0] held_buttons = '0;
    longint       held_sticks[4];
    longint       held_triggers[2];

    int  mismatches = 0;
    int  cycle_count = 0;
    bit  gaps_on = 1'b1;       // random idling on both channels
    logic rx_hold = 1'b0;      // long hold-off of the receiver, driven by its own process
    int  rx_wait = 0;

    gamepad_report_frame_combiner #(
        .BUTTON_BITS (BTN_W),
        .AXIS_BITS   (AXIS_W),
        .COUNT_MAX   (COUNT_LIMIT)
    ) u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .frame_start        (frame_start),
        .buttons            (buttons),
        .left_x             (left_x),
        .left_y             (left_y),
        .right_x            (right_x),
        .right_y            (right_y),
        .left_trigger       (left_trigger),
        .right_trigger      (right_trigger),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .merged_buttons     (merged_buttons),
        .mean_left_x        (mean_left_x),
        .mean_left_y        (mean_left_y),
        .mean_right_x       (mean_right_x),
        .mean_right_y       (mean_right_y),
        .mean_left_trigger  (mean_left_trigger),
        .mean_right_trigger (mean_right_trigger),
        .reports_seen       (reports_seen)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: a hung handshake must not leave the run spinning for ever.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Works out the merged transaction that an accepted report must produce and
    // advances the frame state. The first report of a frame, or any report while
    // the count is still zero after reset, replaces the state outright; later
    // reports AND the buttons in and fold each axis into its mean as
    // (mean * n + sample) / (n + 1), the divide truncating towards zero.
    function automatic frame_merge_t predict_merge(pad_report_t rpt);
        frame_merge_t res;
        longint sample;
        if (rpt.frame_start || frame_reports == 0)
        begin
            held_buttons = rpt.buttons;
            for (int i = 0; i < 4; i++)
                held_sticks[i] = longint'($signed(rpt.sticks[i]));
            for (int i = 0; i < 2; i++)
                held_triggers[i] = longint'(rpt.triggers[i]);
            frame_reports = 1;
        end
        else
        begin
            held_buttons &= rpt.buttons;
            for (int i = 0; i < 4; i++)
            begin
                sample = longint'($signed(rpt.sticks[i]));
                held_sticks[i] = (held_sticks[i] * frame_reports + sample) / (frame_reports + 1);
            end
            for (int i = 0; i < 2; i++)
            begin
                sample = longint'(rpt.triggers[i]);
                held_triggers[i] =
                    (held_triggers[i] * frame_reports + sample) / (frame_reports + 1);
            end
            // The count sticks at its ceiling; the weight stays there too.
            if (frame_reports < COUNT_LIMIT)
                frame_reports++;
        end
        res.buttons = held_buttons;
        for (int i = 0; i < 4; i++)
            res.sticks[i] = held_sticks[i][AXIS_W-1:0];
        for (int i = 0; i < 2; i++)
            res.triggers[i] = held_triggers[i][AXIS_W-1:0];
        res.seen = frame_reports[7:0];
        return res;
    endfunction

    // Presents one report and waits for its transaction. Valid is left high on
    // return, so that a report sent straight afterwards follows without a bubble;
    // anything that pauses the sender must lower it through drain_results.
    task automatic send_report(pad_report_t rpt);
        int gap;
        gap = gaps_on ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        frame_start   <= rpt.frame_start;
        buttons       <= rpt.buttons;
        left_x        <= rpt.sticks[0];
        left_y        <= rpt.sticks[1];
        right_x       <= rpt.sticks[2];
        right_y       <= rpt.sticks[3];
        left_trigger  <= rpt.triggers[0];
        right_trigger <= rpt.triggers[1];
        do
            @(posedge clk);
        while (in_stall);
        expected_merges.push_back(predict_merge(rpt));
    endtask

    // Idles the sender until every owed result has come out. Every report yields
    // a result, so nothing can still be in work once the queue is empty.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_merges.size() != 0);
    endtask

    task automatic note_mismatch(string field, logic [15:0] want, logic [15:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTED)
            $display("mismatch on %s: expected %h, got %h", field, want, got);
    endtask

    // Compares one accepted output transaction with the oldest expectation.
    task automatic check_merge();
        frame_merge_t want;
        frame_merge_t got;
        string stick_names[4];
        stick_names = '{"mean_left_x", "mean_left_y", "mean_right_x", "mean_right_y"};
        if (expected_merges.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTED)
                $display("output transaction with no report waiting for it");
            return;
        end
        want = expected_merges.pop_front();
        got.buttons     = merged_buttons;
        got.sticks      = {mean_right_y, mean_right_x, mean_left_y, mean_left_x};
        got.triggers    = {mean_right_trigger, mean_left_trigger};
        got.seen        = reports_seen;
        if (got.buttons !== want.buttons)
            note_mismatch("merged_buttons", want.buttons, got.buttons);
        for (int i = 0; i < 4; i++)
            if (got.sticks[i] !== want.sticks[i])
                note_mismatch(stick_names[i], want.sticks[i], got.sticks[i]);
        if (got.triggers[0] !== want.triggers[0])
            note_mismatch("mean_left_trigger", want.triggers[0], got.triggers[0]);
        if (got.triggers[1] !== want.triggers[1])
            note_mismatch("mean_right_trigger", want.triggers[1], got.triggers[1]);
        if (got.seen !== want.seen)
            note_mismatch("reports_seen", {8'h00, want.seen}, {8'h00, got.seen});
    endtask

    // Receiver: checks every transaction and then, while gaps are on, stalls for a random
    // number of cycles before the next; the long hold-off overrides this from outside.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            check_merge();
            rx_wait = gaps_on ? $urandom_range(0, 19) : 0;
        end
        if (rx_wait > 0)
        begin
            out_stall <= 1'b1;
            rx_wait--;
        end
        else
            out_stall <= rx_hold;
    end

    // Axis codes lean towards the ends of the range and towards small values
    // around zero, where truncation of negative means shows up.
    function automatic logic [AXIS_W-1:0] rand_axis_code();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0000;
            4: return 16'($urandom_range(0, 8)) - 16'd4;
            default: return 16'($urandom);
        endcase
    endfunction

    // Buttons are mostly dense, otherwise the AND clears to zero after a report or two.
    function automatic pad_report_t rand_report(logic fs);
        pad_report_t rpt;
        rpt.frame_start = fs;
        case ($urandom_range(0, 5))
            0: rpt.buttons = 16'hFFFF;
            1: rpt.buttons = 16'($urandom);
            default: rpt.buttons = 16'($urandom | $urandom | $urandom);
        endcase
        for (int i = 0; i < 4; i++)
            rpt.sticks[i] = rand_axis_code();
        for (int i = 0; i < 2; i++)
            rpt.triggers[i] = rand_axis_code();
        return rpt;
    endfunction

    function automatic pad_report_t make_report(logic fs, logic [15:0] btn,
                                                logic [15:0] lx, logic [15:0] ly,
                                                logic [15:0] rx, logic [15:0] ry,
                                                logic [15:0] lt, logic [15:0] rt);
        pad_report_t rpt;
        rpt.frame_start = fs;
        rpt.buttons     = btn;
        rpt.sticks      = {ry, rx, ly, lx};
        rpt.triggers    = {rt, lt};
        return rpt;
    endfunction

    // The very first report after reset is copied although frame_start is low,
    // and the following reports average full-scale values of opposite sign.
    task automatic test_first_report_after_reset();
        send_report(make_report(1'b0, 16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001,
                                16'hFFFF, 16'h0000));
        send_report(make_report(1'b0, 16'h0000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
                                16'hFFFF, 16'hFFFF));
        send_report(make_report(1'b0, 16'hFFFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000,
                                16'h0000, 16'hFFFF));
        send_report(make_report(1'b0, 16'h5555, 16'hFFFD, 16'h0003, 16'h0000, 16'hFFFF,
                                16'h0001, 16'h8000));
    endtask

    // A raised frame_start in the middle of a frame throws the old means away.
    task automatic test_frame_restart();
        send_report(make_report(1'b1, 16'hA5A5, 16'h1234, 16'hEDCC, 16'h0100, 16'hFF00,
                                16'h4000, 16'hC000));
        send_report(make_report(1'b0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                16'h0000, 16'h0000));
        send_report(make_report(1'b0, 16'h5A5A, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                                16'hFFFF, 16'hFFFF));
        send_report(make_report(1'b1, 16'h0F0F, 16'hFFFF, 16'h0001, 16'hFFFE, 16'h0002,
                                16'h0003, 16'hFFFC));
        send_report(make_report(1'b1, 16'hF0F0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                16'h0000, 16'h0000));
    endtask

    // Small negative means must round towards zero, not towards minus infinity.
    task automatic test_negative_truncation();
        send_report(make_report(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFE, 16'h8000, 16'hFFFF,
                                16'h0001, 16'h0000));
        send_report(make_report(1'b0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFE,
                                16'h0000, 16'h0001));
        send_report(make_report(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001, 16'hFFFF,
                                16'h0002, 16'h0002));
        send_report(make_report(1'b0, 16'hFFFF, 16'h0001, 16'hFFFD, 16'h8000, 16'h0000,
                                16'h0000, 16'h0001));
    endtask

    // Triggers pinned at either end of their unsigned range.
    task automatic test_trigger_extremes();
        send_report(make_report(1'b1, 16'h8001, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                16'h0000, 16'hFFFF));
        send_report(make_report(1'b0, 16'h8001, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                16'hFFFF, 16'h0000));
        send_report(make_report(1'b0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                16'hFFFF, 16'hFFFF));
        send_report(make_report(1'b0, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                16'hFFFF, 16'hFFFF));
    endtask

    // One long frame that drives the count into saturation and well beyond it.
    task automatic test_count_saturation();
        send_report(rand_report(1'b1));
        for (int i = 1; i < COUNT_LIMIT + 20; i++)
        begin
            if (i % 40 == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            send_report(rand_report(1'b0));
        end
        gaps_on = 1'b1;
    endtask

    // Frames of random length; now and then a report carries a stray frame_start.
    task automatic test_random_frames(int num_reports);
        int sent;
        int frame_len;
        sent = 0;
        while (sent < num_reports)
        begin
            frame_len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40)
                                                    : $urandom_range(1, 16);
            gaps_on = ($urandom_range(0, 4) != 0);
            for (int i = 0; i < frame_len && sent < num_reports; i++)
            begin
                send_report(rand_report(i == 0 ? 1'b1 : ($urandom_range(0, 19) == 0)));
                sent++;
            end
        end
        gaps_on = 1'b1;
    endtask

    // The receiver holds off for a long stretch in a process of its own while the
    // sender keeps offering back-to-back reports, so the output register and the
    // sequencer both fill and the input channel has to stall.
    task automatic test_output_backpressure();
        gaps_on = 1'b0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (300) @(posedge clk);
                rx_hold <= 1'b0;
            end
        join_none
        send_report(rand_report(1'b1));
        for (int i = 0; i < 19; i++)
            send_report(rand_report(1'b0));
        drain_results();
        gaps_on = 1'b1;
    endtask

    // The sender pauses until every owed result is out, then resumes mid-frame.
    task automatic test_pause_and_resume();
        send_report(rand_report(1'b1));
        for (int i = 0; i < 9; i++)
            send_report(rand_report(1'b0));
        drain_results();
        for (int i = 0; i < 10; i++)
            send_report(rand_report(1'b0));
    endtask

    initial
    begin
        held_sticks   = '{default: 0};
        held_triggers = '{default: 0};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_report_after_reset();
        test_frame_restart();
        test_negative_truncation();
        test_trigger_extremes();
        test_count_saturation();
        test_output_backpressure();
        test_random_frames(180);
        test_pause_and_resume();
        test_random_frames(60);

        // Let the last results out, then watch a while longer for stray transactions.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_merges.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[gamepad_report_frame_combiner.f]
hw/rtl/gprfc_pkg.sv
hw/rtl/gprfc_lane.sv
hw/rtl/gprfc_ctrl.sv
hw/rtl/gamepad_report_frame_combiner.sv
dv/tb.sv
